// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the script line tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SLT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define SLT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/slt_pkg.sv -----
// ---------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the script line tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

	// result kinds
	localparam logic [2:0] KIND_BYTE = 3'd0;
	localparam logic [2:0] KIND_TEND = 3'd1;
	localparam logic [2:0] KIND_CMD  = 3'd2;
	localparam logic [2:0] KIND_DONE = 3'd3;
	localparam logic [2:0] KIND_ERR  = 3'd4;

	// error status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SIZE   = 3'd1;
	localparam logic [2:0] ST_HEADER = 3'd2;
	localparam logic [2:0] ST_LINE   = 3'd3;
	localparam logic [2:0] ST_LIMIT  = 3'd4;

	// configuration register indexes and reset values
	localparam logic [1:0] REG_MAX_LINE   = 2'd0;
	localparam logic [1:0] REG_MAX_CMDS   = 2'd1;
	localparam logic [1:0] REG_MAX_BYTES  = 2'd2;
	localparam logic [15:0] MAX_LINE_RST  = 16'd8192;
	localparam logic [15:0] MAX_CMDS_RST  = 16'd1024;
	localparam logic [20:0] MAX_BYTES_RST = 21'h100000;

	localparam int          MAX_RES    = 4;
	localparam logic [2:0]  HDR_LEN    = 3'd5;
	localparam logic [20:0] LINE_MAX   = 21'h1FFFFF;
	localparam logic [20:0] LINE_FIRST = 21'd2;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_LOW   = 8'h21;
	localparam logic [7:0] CH_HIGH  = 8'h7E;

	typedef struct packed {
		logic [15:0] max_line_length;
		logic [15:0] max_commands;
		logic [20:0] max_script_bytes;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  token_byte;
		logic        is_verb;
		logic [20:0] line_num;
		logic [2:0]  status;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [2:0]                count;
		result_t [MAX_RES-1:0]     item;
	} res_bundle_t;

	// header magic "VSP1" LF
	function automatic logic [7:0] magic_byte(logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h56;
			3'd1: b = 8'h53;
			3'd2: b = 8'h50;
			3'd3: b = 8'h31;
			3'd4: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/script_line_tokenizer_unit.sv -----
// ---------------------------------------------------------------------------
// script_line_tokenizer_unit
// Script header check, line validation and tokenizing, one byte a beat.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one script byte a beat in s_tdata[7:0]; s_tlast marks the
//   final byte of a script. m_* carries results: m_tuser is the kind, m_tlast
//   marks the last result caused by one input byte.
//   cfg_* writes the limit registers (0 line length, 1 commands, 2 bytes);
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A byte passes the input register and then the result buffer before
//   its first result beat. Bytes with no result or one result go at one
//   byte per cycle while m_tready is high. A byte with n results (up to
//   four) keeps the buffer busy until all n have left; the next byte with
//   results waits in the input register until the last of them leaves.
// Reset: all script state returns to the header phase, line counter 2, limits
//   to 8192 / 1024 / 1048576. After the final byte the script state rearms
//   itself; registers keep their values.
// Stall: when m_tready is low the results wait in the result buffer, the
//   input register fills and s_tready drops until results drain.
// ---------------------------------------------------------------------------
`default_nettype none

module script_line_tokenizer_unit #(
	parameter int SCRIPT_BYTES_LIMIT = 1048576
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // end_of_script
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] token_byte, [8] is_verb,
	                                    // [29:9] line_num, [32:30] status
	output logic [2:0]       m_tuser,   // [2:0] kind
	output logic             m_tlast,   // run_last
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [20:0] cfg_data
);
	import slt_pkg::*;

	cfg_t        cfg;
	logic        load_ok;
	logic        load;
	res_bundle_t bundle;
	result_t     head;

	slt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slt_core #(
		.SCRIPT_BYTES_LIMIT (SCRIPT_BYTES_LIMIT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_byte   (s_tdata),
		.s_last   (s_tlast),
		.cfg      (cfg),
		.load_ok  (load_ok),
		.load     (load),
		.bundle   (bundle)
	);

	slt_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.bundle   (bundle),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	// pack the head result onto the stream
	assign m_tdata = {7'd0, head.status, head.line_num, head.is_verb, head.token_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.run_last;

endmodule

`default_nettype wire

// ----- hdl/slt_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// slt_cfg_regs
// Configuration register file: line, command and script size limits.
// ---------------------------------------------------------------------------
`default_nettype none

module slt_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [20:0]   cfg_data,
	output slt_pkg::cfg_t      cfg
);
	import slt_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_line_length  <= MAX_LINE_RST;
			cfg_q.max_commands     <= MAX_CMDS_RST;
			cfg_q.max_script_bytes <= MAX_BYTES_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_LINE:  cfg_q.max_line_length  <= cfg_data[15:0];
				REG_MAX_CMDS:  cfg_q.max_commands     <= cfg_data[15:0];
				REG_MAX_BYTES: cfg_q.max_script_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/slt_core.sv -----
// ---------------------------------------------------------------------------
// slt_core
// Input register, tokenizer state and single-pass result generation.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module slt_core #(
	parameter int SCRIPT_BYTES_LIMIT = 1048576
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_byte,
	input  wire logic               s_last,
	input  wire slt_pkg::cfg_t      cfg,
	input  wire logic               load_ok,
	output logic                    load,
	output slt_pkg::res_bundle_t    bundle
);
	import slt_pkg::*;

	localparam int BW = $clog2(SCRIPT_BYTES_LIMIT + 2);
	localparam int CW = (BW > 21) ? BW : 21;
	localparam logic [CW-1:0] PLIM = CW'(SCRIPT_BYTES_LIMIT);

	typedef enum logic [2:0] {
		PH_HEADER, PH_BETWEEN, PH_PLAIN, PH_QUOTED, PH_ESCAPE, PH_COMMENT, PH_FAILED
	} phase_t;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// tokenizer state
	phase_t        phase_q;
	logic [2:0]    hidx_q;
	logic          hbad_q;
	logic          pcr_q;
	logic [16:0]   llen_q;
	logic [20:0]   lcnt_q;
	logic [BW-1:0] bcnt_q;
	logic [16:0]   ccnt_q;
	logic          lht_q;

	// next state
	phase_t        ph;
	logic [2:0]    hidx;
	logic          hbad;
	logic          pcr;
	logic [16:0]   llen;
	logic [20:0]   lcnt;
	logic [BW-1:0] bcnt;
	logic [16:0]   ccnt;
	logic          lht;

	logic [CW-1:0] lim;
	logic          ws;
	logic          fin;
	logic          fin_adv;
	logic          fin_end;
	logic [2:0]    n;
	result_t [MAX_RES-1:0] res;
	logic          take;

	function automatic result_t mk(logic [2:0] k, logic [7:0] b, logic v,
		logic [20:0] ln, logic [2:0] st);
		result_t r;
		r.kind        = k;
		r.token_byte  = b;
		r.is_verb     = v;
		r.line_num    = ln;
		r.status      = st;
		r.run_last    = 1'b0;
		return r;
	endfunction

	// one step of the script parser for the byte in the input register
	always_comb begin
		ph = phase_q; hidx = hidx_q; hbad = hbad_q; pcr = pcr_q; llen = llen_q;
		lcnt = lcnt_q; bcnt = bcnt_q; ccnt = ccnt_q; lht = lht_q;
		n = 3'd0; res = '0; fin = 1'b0; fin_adv = 1'b0; fin_end = 1'b0;
		lim = (CW'(cfg.max_script_bytes) > PLIM) ? PLIM : CW'(cfg.max_script_bytes);
		ws = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);

		if (ph != PH_FAILED) begin
			bcnt = bcnt + BW'(1);
			if (CW'(bcnt) > lim) begin
				res[n[1:0]] = mk(KIND_ERR, 8'd0, 1'b0,
					(ph == PH_HEADER) ? 21'd1 : lcnt, ST_SIZE);
				n = n + 3'd1;
				ph = PH_FAILED;
			end else if (ph == PH_HEADER) begin
				if (byte_s1 != magic_byte(hidx)) hbad = 1'b1;
				hidx = hidx + 3'd1;
				if (hidx == HDR_LEN) begin
					if (hbad) begin
						res[n[1:0]] = mk(KIND_ERR, 8'd0, 1'b0, 21'd1, ST_HEADER);
						n = n + 3'd1;
						ph = PH_FAILED;
					end else begin
						ph = PH_BETWEEN;
					end
				end
			end else if (pcr || byte_s1 == CH_LF) begin
				if (byte_s1 == CH_LF) begin
					fin = 1'b1;
				end else begin
					res[n[1:0]] = mk(KIND_ERR, 8'd0, 1'b0, lcnt, ST_LINE);
					n = n + 3'd1;
					ph = PH_FAILED;
				end
			end else if (byte_s1 == CH_CR) begin
				pcr = 1'b1;
			end else if (!(byte_s1 == CH_TAB || byte_s1 == CH_SPACE
				|| (byte_s1 >= CH_LOW && byte_s1 <= CH_HIGH))) begin
				res[n[1:0]] = mk(KIND_ERR, 8'd0, 1'b0, lcnt, ST_LINE);
				n = n + 3'd1;
				ph = PH_FAILED;
			end else begin
				llen = llen + 17'd1;
				if (llen > {1'b0, cfg.max_line_length}) begin
					res[n[1:0]] = mk(KIND_ERR, 8'd0, 1'b0, lcnt, ST_LINE);
					n = n + 3'd1;
					ph = PH_FAILED;
				end else begin
					// token splitting
					unique case (ph)
						PH_BETWEEN: begin
							if (!ws) begin
								if (byte_s1 == CH_HASH) ph = PH_COMMENT;
								else if (byte_s1 == CH_QUOTE) ph = PH_QUOTED;
								else begin
									res[n[1:0]] = mk(KIND_BYTE, byte_s1, !lht, lcnt, ST_OK);
									n = n + 3'd1;
									ph = PH_PLAIN;
								end
							end
						end
						PH_PLAIN: begin
							if (ws) begin
								res[n[1:0]] = mk(KIND_TEND, 8'd0, !lht, lcnt, ST_OK);
								n = n + 3'd1;
								lht = 1'b1;
								ph = PH_BETWEEN;
							end else begin
								res[n[1:0]] = mk(KIND_BYTE, byte_s1, !lht, lcnt, ST_OK);
								n = n + 3'd1;
							end
						end
						PH_QUOTED: begin
							if (byte_s1 == CH_QUOTE) begin
								res[n[1:0]] = mk(KIND_TEND, 8'd0, !lht, lcnt, ST_OK);
								n = n + 3'd1;
								lht = 1'b1;
								ph = PH_BETWEEN;
							end else if (byte_s1 == CH_BSL) begin
								ph = PH_ESCAPE;
							end else begin
								res[n[1:0]] = mk(KIND_BYTE, byte_s1, !lht, lcnt, ST_OK);
								n = n + 3'd1;
							end
						end
						PH_ESCAPE: begin
							res[n[1:0]] = mk(KIND_BYTE,
								(byte_s1 == CH_N) ? CH_LF : (byte_s1 == CH_T) ? CH_TAB : byte_s1,
								!lht, lcnt, ST_OK);
							n = n + 3'd1;
							ph = PH_QUOTED;
						end
						default: ;
					endcase
				end
			end
		end

		// line finish: first for LF, second for end of script
		for (int p = 0; p < 2; p++) begin
			if (p == 1) begin
				fin = 1'b0;
				if (last_s1 && ph != PH_FAILED) begin
					if (ph == PH_HEADER) begin
						res[n[1:0]] = mk(KIND_ERR, 8'd0, 1'b0, 21'd1, ST_SIZE);
						n = n + 3'd1;
						ph = PH_FAILED;
					end else begin
						fin = 1'b1;
						fin_end = 1'b1;
					end
				end
			end
			fin_adv = (p == 0);
			if (fin) begin
				if (ph == PH_ESCAPE) begin
					res[n[1:0]] = mk(KIND_BYTE, CH_BSL, !lht, lcnt, ST_OK);
					n = n + 3'd1;
				end
				if (ph == PH_ESCAPE || ph == PH_PLAIN || ph == PH_QUOTED) begin
					if (n < 3'(MAX_RES)) begin
						res[n[1:0]] = mk(KIND_TEND, 8'd0, !lht, lcnt, ST_OK);
						n = n + 3'd1;
					end
					lht = 1'b1;
				end
				if (lht) ccnt = ccnt + 17'd1;
				if (lht && ccnt > {1'b0, cfg.max_commands}) begin
					if (n < 3'(MAX_RES)) begin
						res[n[1:0]] = mk(KIND_ERR, 8'd0, 1'b0, lcnt, ST_LIMIT);
						n = n + 3'd1;
					end
					ph = PH_FAILED;
				end else begin
					if (lht && n < 3'(MAX_RES)) begin
						res[n[1:0]] = mk(KIND_CMD, 8'd0, 1'b0, lcnt, ST_OK);
						n = n + 3'd1;
					end
					ph = PH_BETWEEN;
					pcr = 1'b0;
					llen = 17'd0;
					lht = 1'b0;
					if (fin_adv && lcnt < LINE_MAX) lcnt = lcnt + 21'd1;
				end
			end
		end

		if (fin_end && ph != PH_FAILED && n < 3'(MAX_RES)) begin
			res[n[1:0]] = mk(KIND_DONE, 8'd0, 1'b0, lcnt, ST_OK);
			n = n + 3'd1;
		end

		// rearm for the next script
		if (last_s1) begin
			ph = PH_HEADER; hidx = 3'd0; hbad = 1'b0; pcr = 1'b0; llen = 17'd0;
			lcnt = LINE_FIRST; bcnt = '0; ccnt = 17'd0; lht = 1'b0;
		end

		if (n != 3'd0) res[n[1:0] - 2'd1].run_last = 1'b1;
	end

	// items without results retire at once; others wait for the output buffer
	assign take     = valid_s1 && (n == 3'd0 || load_ok);
	assign load     = take && (n != 3'd0);
	assign s_tready = !valid_s1 || take;
	assign bundle.count = n;
	assign bundle.item  = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_byte;
			last_s1 <= s_last;
		end
	end

	// state commit when the item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= 3'd0;
			hbad_q  <= 1'b0;
			pcr_q   <= 1'b0;
			llen_q  <= 17'd0;
			lcnt_q  <= LINE_FIRST;
			bcnt_q  <= '0;
			ccnt_q  <= 17'd0;
			lht_q   <= 1'b0;
		end else if (take) begin
			phase_q <= ph;
			hidx_q  <= hidx;
			hbad_q  <= hbad;
			pcr_q   <= pcr;
			llen_q  <= llen;
			lcnt_q  <= lcnt;
			bcnt_q  <= bcnt;
			ccnt_q  <= ccnt;
			lht_q   <= lht;
		end
	end

	`SLT_ASSERT(a_failed_silent, clk, arst_n, (valid_s1 && phase_q == PH_FAILED) |-> (n == 3'd0), "failed script produced a result")
	`SLT_NEVER(a_line_floor, clk, arst_n, lcnt_q < LINE_FIRST, "line counter below first body line")

endmodule

`default_nettype wire

// ----- hdl/slt_out_buf.sv -----
// ---------------------------------------------------------------------------
// slt_out_buf
// Result register: holds up to four results of one byte, sends one a beat.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module slt_out_buf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire slt_pkg::res_bundle_t  bundle,
	output logic                       load_ok,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output slt_pkg::result_t           head
);
	import slt_pkg::*;

	result_t [MAX_RES-1:0] buf_q;
	logic [2:0]            cnt_q;
	logic                  beat;

	assign m_tvalid = (cnt_q != 3'd0);
	assign beat     = m_tvalid && m_tready;
	assign load_ok  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_tready);
	assign head     = buf_q[0];

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= bundle.count;
		end else if (beat) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// payload: load or shift toward the head
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= bundle.item;
		end else if (beat) begin
			for (int i = 0; i < MAX_RES - 1; i++) buf_q[i] <= buf_q[i+1];
		end
	end

	`SLT_NEVER(a_cnt_range, clk, arst_n, cnt_q > 3'(MAX_RES), "result count out of range")
	`SLT_ASSERT(a_load_free, clk, arst_n, load |-> load_ok, "load into a busy result buffer")
	`SLT_ASSERT(a_last_mark, clk, arst_n, (cnt_q == 3'd1) |-> head.run_last, "final result lacks run mark")

endmodule

`default_nettype wire
